// ===== hdl/qsg_pkg.sv =====
package qsg_pkg;

  localparam int unsigned NumMotors = 4;
  localparam int unsigned PosW      = 16;
  localparam int unsigned PulseW    = 8;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned CfgW      = 64;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [CfgW-1:0] TravelMaxReset = 64'h2710_2710_2710_2710;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_DISABLED   = 3'd1,
    ST_TRAVEL_MAX = 3'd2,
    ST_LIMIT_MIN  = 3'd3,
    ST_TRAVEL_MIN = 3'd4,
    ST_RANGE      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REQ_SINGLE = 2'd0,
    REQ_MULTI  = 2'd1,
    REQ_LOAD   = 2'd2
  } req_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRAVEL_MIN  = 3'd0,
    CFG_TRAVEL_MAX  = 3'd1,
    CFG_PULSE_DELAY = 3'd2,
    CFG_ENABLE      = 3'd3,
    CFG_INVERT      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [PulseW-1:0] pulse_m0;
    logic signed [PulseW-1:0] pulse_m1;
    logic signed [PulseW-1:0] pulse_m2;
    logic signed [PulseW-1:0] pulse_m3;
    logic [3:0]               limit_switch_raw;
    logic signed [PosW-1:0]   load_pos_m0;
    logic signed [PosW-1:0]   load_pos_m1;
    logic signed [PosW-1:0]   load_pos_m2;
    logic signed [PosW-1:0]   load_pos_m3;
  } req_t;

  typedef struct packed {
    logic [2:0]             status_code;
    logic [3:0]             step_mask;
    logic [3:0]             direction_bits;
    logic [DelayW-1:0]      delay_us;
    logic signed [PosW-1:0] position_m0;
    logic signed [PosW-1:0] position_m1;
    logic signed [PosW-1:0] position_m2;
    logic signed [PosW-1:0] position_m3;
  } rsp_t;

  typedef struct packed {
    logic [NumMotors-1:0][PosW-1:0]   travel_min;
    logic [NumMotors-1:0][PosW-1:0]   travel_max;
    logic [NumMotors-1:0][DelayW-1:0] pulse_delay;
    logic [NumMotors-1:0]             enable;
    logic                             invert;
  } cfg_t;

  typedef struct packed {
    logic                   fail;
    status_e                code;
    logic                   set_dir;
    logic                   dir;
    logic                   stepped;
    logic signed [PosW-1:0] new_pos;
  } chk_t;

endpackage

// ===== hdl/qsg_stream_if.sv =====
interface qsg_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/quad_stepper_step_gate_unit.sv =====
// Step gate for four stepper motors.
// Requests arrive on req_i (valid/ready) and each gives exactly one result on
// rsp_o (valid/ready). Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i, one register per cycle, and only while no item is
// in flight, a rule on the user that the block itself does not enforce;
// indexes beyond the register list are ignored. An accepted item is held in
// the input register, where all four motors are checked side by side against
// the stored positions, and its result is loaded into the output register,
// which drives rsp_o.valid, once that register is free. Positions and direction
// bits are updated at that same edge, so the following item already sees them.
// Throughput is one item per cycle while rsp_o is not stalled; once both
// registers hold an item, req_i.ready follows rsp_o.ready, so a stalled rsp_o
// holds the result and fills the input register before req_i.ready drops.
// Reset clears positions, directions and both pipeline valid flags, and loads
// the travel maxima with 10000 for every motor; other registers reset to zero.
module quad_stepper_step_gate_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qsg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qsg_pkg::CfgW-1:0]     cfg_wdata_i,
  qsg_stream_if.sink                   req_i,
  qsg_stream_if.source                 rsp_o
);
  import qsg_pkg::*;

  cfg_t cfg;

  logic  s1_valid_q;
  req_t  s1_q;
  logic  rsp_valid_q;
  rsp_t  rsp_q;
  rsp_t  rsp_d;
  logic  out_free;
  logic  adv;

  logic [NumMotors-1:0][PosW-1:0] pos_q, pos_d;
  logic [NumMotors-1:0]           dir_q, dir_d;

  logic [NumMotors-1:0][PulseW-1:0] pulse;
  logic [NumMotors-1:0][PosW-1:0]   load_pos;
  logic [NumMotors-1:0]             at_min;
  chk_t [NumMotors-1:0]             chk;
  logic [NumMotors-1:0]             ok_before;
  logic                             all_ok;
  logic [NumMotors-1:0]             mask;
  logic [DelayW-1:0]                delay;
  status_e                          status;

  qsg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign adv         = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      pos_q       <= '0;
      dir_q       <= '0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (out_free) begin
        rsp_valid_q <= adv;
      end
      pos_q <= pos_d;
      dir_q <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_q <= req_i.data;
    end
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign pulse    = {s1_q.pulse_m3, s1_q.pulse_m2, s1_q.pulse_m1, s1_q.pulse_m0};
  assign load_pos = {s1_q.load_pos_m3, s1_q.load_pos_m2, s1_q.load_pos_m1,
                     s1_q.load_pos_m0};
  assign at_min   = s1_q.limit_switch_raw ^ {NumMotors{cfg.invert}};

  for (genvar g = 0; g < NumMotors; g++) begin : g_motor
    qsg_motor_check u_chk (
      .kind_i     (s1_q.req_type),
      .pulse_i    ($signed(pulse[g])),
      .enable_i   (cfg.enable[g]),
      .at_min_i   (at_min[g]),
      .pos_i      ($signed(pos_q[g])),
      .min_i      ($signed(cfg.travel_min[g])),
      .max_i      ($signed(cfg.travel_max[g])),
      .load_pos_i ($signed(load_pos[g])),
      .chk_o      (chk[g])
    );
  end

  // first failing motor sets the status; ok_before is cleared for every motor after it
  always_comb begin
    logic run_ok;
    run_ok = 1'b1;
    status = ST_OK;
    for (int i = 0; i < NumMotors; i++) begin
      ok_before[i] = run_ok;
      if (run_ok && chk[i].fail) begin
        status = chk[i].code;
      end
      run_ok = run_ok & ~chk[i].fail;
    end
    all_ok = run_ok;
  end

  always_comb begin
    pos_d = pos_q;
    dir_d = dir_q;
    mask  = '0;
    rsp_d = '0;
    rsp_d.status_code = status;
    case (req_kind_e'(s1_q.req_type))
      REQ_SINGLE: begin
        for (int i = 0; i < NumMotors; i++) begin
          if (ok_before[i] && chk[i].set_dir) begin
            dir_d[i] = chk[i].dir;
          end
          if (all_ok) begin
            pos_d[i] = chk[i].new_pos;
            mask[i]  = chk[i].stepped;
          end
        end
      end
      REQ_MULTI: begin
        // a failing motor reports its old position, so it may be written too
        for (int i = 0; i < NumMotors; i++) begin
          if (ok_before[i]) begin
            pos_d[i] = chk[i].new_pos;
            if (chk[i].set_dir) begin
              dir_d[i] = chk[i].dir;
            end
          end
        end
      end
      REQ_LOAD: begin
        for (int i = 0; i < NumMotors; i++) begin
          pos_d[i] = chk[i].new_pos;
        end
        rsp_d.status_code = ST_OK;
      end
      default: rsp_d.status_code = ST_RANGE;
    endcase
    if (!adv) begin
      pos_d = pos_q;
      dir_d = dir_q;
    end

    delay = '0;
    for (int i = 0; i < NumMotors; i++) begin
      if (mask[i] && (cfg.pulse_delay[i] > delay)) begin
        delay = cfg.pulse_delay[i];
      end
    end

    rsp_d.step_mask      = mask;
    rsp_d.direction_bits = dir_d;
    rsp_d.delay_us       = delay;
    rsp_d.position_m0    = $signed(pos_d[0]);
    rsp_d.position_m1    = $signed(pos_d[1]);
    rsp_d.position_m2    = $signed(pos_d[2]);
    rsp_d.position_m3    = $signed(pos_d[3]);
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  a_mask_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_q.step_mask != '0) |-> rsp_q.status_code == ST_OK)
    else $error("step pulses reported with a failing status");

  a_delay_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_q.delay_us != '0) |-> rsp_q.step_mask != '0)
    else $error("pulse delay reported without any step");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(pos_q) && $stable(dir_q))
    else $error("motor state changed without an item");

  a_rsp_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_q.position_m0 == pos_q[0]) && (rsp_q.direction_bits == dir_q))
    else $error("pending result disagrees with stored motor state");

endmodule

// ===== hdl/qsg_cfg_regs.sv =====
module qsg_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [qsg_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [qsg_pkg::CfgW-1:0]     wdata_i,
  output qsg_pkg::cfg_t                cfg_o
);
  import qsg_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.travel_min  <= '0;
      cfg_q.travel_max  <= TravelMaxReset;
      cfg_q.pulse_delay <= '0;
      cfg_q.enable      <= '0;
      cfg_q.invert      <= 1'b0;
    end else if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_TRAVEL_MIN:  cfg_q.travel_min  <= wdata_i;
        CFG_TRAVEL_MAX:  cfg_q.travel_max  <= wdata_i;
        CFG_PULSE_DELAY: cfg_q.pulse_delay <= wdata_i;
        CFG_ENABLE:      cfg_q.enable      <= wdata_i[NumMotors-1:0];
        CFG_INVERT:      cfg_q.invert      <= wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/qsg_motor_check.sv =====
module qsg_motor_check (
  input  logic [1:0]                         kind_i,
  input  logic signed [qsg_pkg::PulseW-1:0]  pulse_i,
  input  logic                               enable_i,
  input  logic                               at_min_i,
  input  logic signed [qsg_pkg::PosW-1:0]    pos_i,
  input  logic signed [qsg_pkg::PosW-1:0]    min_i,
  input  logic signed [qsg_pkg::PosW-1:0]    max_i,
  input  logic signed [qsg_pkg::PosW-1:0]    load_pos_i,
  output qsg_pkg::chk_t                      chk_o
);
  import qsg_pkg::*;

  logic signed [PosW:0] np;

  // one extra bit so a move past either end of the range compares correctly
  assign np = $signed({pos_i[PosW-1], pos_i})
              + $signed({{(PosW+1-PulseW){pulse_i[PulseW-1]}}, pulse_i});

  always_comb begin
    chk_o         = '0;
    chk_o.code    = ST_OK;
    chk_o.new_pos = pos_i;
    case (req_kind_e'(kind_i))
      REQ_SINGLE: begin
        if (pulse_i == PulseW'(1)) begin
          if (!enable_i) begin
            chk_o.fail = 1'b1;
            chk_o.code = ST_DISABLED;
          end else if (pos_i >= max_i) begin
            chk_o.fail = 1'b1;
            chk_o.code = ST_TRAVEL_MAX;
          end else begin
            chk_o.set_dir = 1'b1;
            chk_o.dir     = 1'b1;
            chk_o.stepped = 1'b1;
            chk_o.new_pos = pos_i + PosW'(1);
          end
        end else if (pulse_i == {PulseW{1'b1}}) begin
          if (!enable_i) begin
            chk_o.fail = 1'b1;
            chk_o.code = ST_DISABLED;
          end else if (at_min_i) begin
            chk_o.fail = 1'b1;
            chk_o.code = ST_LIMIT_MIN;
          end else if (pos_i <= min_i) begin
            chk_o.fail = 1'b1;
            chk_o.code = ST_TRAVEL_MIN;
          end else begin
            chk_o.set_dir = 1'b1;
            chk_o.dir     = 1'b0;
            chk_o.stepped = 1'b1;
            chk_o.new_pos = pos_i - PosW'(1);
          end
        end else if (pulse_i != '0) begin
          chk_o.fail = 1'b1;
          chk_o.code = ST_RANGE;
        end
      end
      REQ_MULTI: begin
        if (pulse_i > $signed(PulseW'(0))) begin
          if (!enable_i) begin
            chk_o.fail = 1'b1;
            chk_o.code = ST_DISABLED;
          end else if (np > max_i) begin
            chk_o.fail = 1'b1;
            chk_o.code = ST_TRAVEL_MAX;
          end else begin
            chk_o.set_dir = 1'b1;
            chk_o.dir     = 1'b1;
            chk_o.new_pos = $signed(np[PosW-1:0]);
          end
        end else if (pulse_i < $signed(PulseW'(0))) begin
          if (!enable_i) begin
            chk_o.fail = 1'b1;
            chk_o.code = ST_DISABLED;
          end else if (at_min_i) begin
            chk_o.fail = 1'b1;
            chk_o.code = ST_LIMIT_MIN;
          end else if (np < min_i) begin
            chk_o.fail = 1'b1;
            chk_o.code = ST_TRAVEL_MIN;
          end else begin
            chk_o.set_dir = 1'b1;
            chk_o.dir     = 1'b0;
            chk_o.new_pos = $signed(np[PosW-1:0]);
          end
        end
      end
      REQ_LOAD: chk_o.new_pos = load_pos_i;
      default: ;
    endcase
  end

endmodule

// ===== tb/tb_quad_stepper_step_gate_unit.sv =====
module tb_quad_stepper_step_gate_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import qsg_pkg::*;

  localparam logic [1:0]         REQ_SPARE      = 2'd3;  // unused request kind
  localparam logic [CfgIdxW-1:0] CFG_NONE       = 3'd7;  // index past the register list
  localparam int                 WATCHDOG_LIMIT = 2000;
  localparam int                 PHASE_ITEMS    = 150;
  localparam int                 DRAIN_CYCLES   = 4;
  localparam int                 HOLD_CYCLES    = 300;

  typedef struct {
    logic               is_cfg;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CfgW-1:0]    reg_val;
    req_t               req;
    logic               known;
    rsp_t               want;
  } gate_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  qsg_stream_if #(.T(req_t)) req_if ();
  qsg_stream_if #(.T(rsp_t)) rsp_if ();

  quad_stepper_step_gate_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the gate: registers, positions and direction bits
  cfg_t                   gate_cfg;
  logic signed [PosW-1:0] motor_pos [NumMotors];
  logic [NumMotors-1:0]   motor_dir;

  rsp_t      gate_expected [$];
  gate_row_t gate_script [$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_len      = 0;
  int mismatches    = 0;
  int items_sent    = 0;
  int reg_writes    = 0;
  int status_seen [8];

  function automatic rsp_t gate_step(req_t r);
    int                   step_cnt [NumMotors];
    int                   next_pos;
    int                   lo;
    int                   hi;
    logic [NumMotors-1:0] sw_hit;
    logic [NumMotors-1:0] mask;
    logic [DelayW-1:0]    dly;
    status_e              st;
    rsp_t                 res;
    step_cnt[0] = r.pulse_m0;
    step_cnt[1] = r.pulse_m1;
    step_cnt[2] = r.pulse_m2;
    step_cnt[3] = r.pulse_m3;
    sw_hit = r.limit_switch_raw ^ {NumMotors{gate_cfg.invert}};
    st     = ST_OK;
    mask   = '0;
    dly    = '0;
    case (r.req_type)
      REQ_SINGLE: begin
        // directions already set survive a later failure
        for (int i = 0; i < NumMotors; i++) begin
          lo = $signed(gate_cfg.travel_min[i]);
          hi = $signed(gate_cfg.travel_max[i]);
          if (st == ST_OK) begin
            if (step_cnt[i] == 1) begin
              if (!gate_cfg.enable[i]) st = ST_DISABLED;
              else if (int'(motor_pos[i]) >= hi) st = ST_TRAVEL_MAX;
              else motor_dir[i] = 1'b1;
            end else if (step_cnt[i] == -1) begin
              if (!gate_cfg.enable[i]) st = ST_DISABLED;
              else if (sw_hit[i]) st = ST_LIMIT_MIN;
              else if (int'(motor_pos[i]) <= lo) st = ST_TRAVEL_MIN;
              else motor_dir[i] = 1'b0;
            end else if (step_cnt[i] != 0) begin
              st = ST_RANGE;
            end
          end
        end
        if (st == ST_OK) begin
          for (int i = 0; i < NumMotors; i++) begin
            if (step_cnt[i] != 0) begin
              next_pos     = int'(motor_pos[i]) + step_cnt[i];
              motor_pos[i] = next_pos[PosW-1:0];
              mask[i]      = 1'b1;
              if (gate_cfg.pulse_delay[i] > dly) dly = gate_cfg.pulse_delay[i];
            end
          end
        end
      end
      REQ_MULTI: begin
        // motor by motor: earlier motors keep their move on a failure
        for (int i = 0; i < NumMotors; i++) begin
          lo       = $signed(gate_cfg.travel_min[i]);
          hi       = $signed(gate_cfg.travel_max[i]);
          next_pos = int'(motor_pos[i]) + step_cnt[i];
          if (st == ST_OK) begin
            if (step_cnt[i] > 0) begin
              if (!gate_cfg.enable[i]) st = ST_DISABLED;
              else if (next_pos > hi) st = ST_TRAVEL_MAX;
              else begin
                motor_dir[i] = 1'b1;
                motor_pos[i] = next_pos[PosW-1:0];
              end
            end else if (step_cnt[i] < 0) begin
              if (!gate_cfg.enable[i]) st = ST_DISABLED;
              else if (sw_hit[i]) st = ST_LIMIT_MIN;
              else if (next_pos < lo) st = ST_TRAVEL_MIN;
              else begin
                motor_dir[i] = 1'b0;
                motor_pos[i] = next_pos[PosW-1:0];
              end
            end
          end
        end
      end
      REQ_LOAD: begin
        motor_pos[0] = r.load_pos_m0;
        motor_pos[1] = r.load_pos_m1;
        motor_pos[2] = r.load_pos_m2;
        motor_pos[3] = r.load_pos_m3;
      end
      default: begin
        st = ST_RANGE;
      end
    endcase
    res.status_code    = st;
    res.step_mask      = mask;
    res.direction_bits = motor_dir;
    res.delay_us       = dly;
    res.position_m0    = motor_pos[0];
    res.position_m1    = motor_pos[1];
    res.position_m2    = motor_pos[2];
    res.position_m3    = motor_pos[3];
    return res;
  endfunction

  function automatic req_t mk_req(logic [1:0] kind, int p0, int p1, int p2, int p3,
                                  logic [3:0] sw, int l0 = 0, int l1 = 0, int l2 = 0,
                                  int l3 = 0);
    req_t r;
    r.req_type         = kind;
    r.pulse_m0         = 8'(p0);
    r.pulse_m1         = 8'(p1);
    r.pulse_m2         = 8'(p2);
    r.pulse_m3         = 8'(p3);
    r.limit_switch_raw = sw;
    r.load_pos_m0      = 16'(l0);
    r.load_pos_m1      = 16'(l1);
    r.load_pos_m2      = 16'(l2);
    r.load_pos_m3      = 16'(l3);
    return r;
  endfunction

  // typed-in results never pulse, so mask and delay stay zero
  function automatic rsp_t mk_rsp(status_e st, logic [3:0] dirs, int q0 = 0, int q1 = 0,
                                  int q2 = 0, int q3 = 0);
    rsp_t r;
    r.status_code    = st;
    r.step_mask      = '0;
    r.direction_bits = dirs;
    r.delay_us       = '0;
    r.position_m0    = 16'(q0);
    r.position_m1    = 16'(q1);
    r.position_m2    = 16'(q2);
    r.position_m3    = 16'(q3);
    return r;
  endfunction

  function automatic void add_req(req_t r, logic known = 1'b0, rsp_t want = '0);
    gate_script.push_back('{1'b0, '0, '0, r, known, want});
  endfunction

  function automatic void add_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    gate_script.push_back('{1'b1, idx, val, '0, 1'b0, '0});
  endfunction

  // mostly well-formed requests near the travel limits, plus raw noise
  function automatic req_t rand_item();
    logic [127:0] noise;
    req_t         r;
    int           roll;
    noise = {$urandom, $urandom, $urandom, $urandom};
    r     = noise[$bits(req_t)-1:0];
    roll  = $urandom_range(99);
    if ($urandom_range(99) < 75) r.limit_switch_raw = {4{gate_cfg.invert}};
    if (roll < 45) begin
      r.req_type = REQ_SINGLE;
      r.pulse_m0 = 8'($urandom_range(2) - 1);
      r.pulse_m1 = 8'($urandom_range(2) - 1);
      r.pulse_m2 = 8'($urandom_range(2) - 1);
      r.pulse_m3 = 8'($urandom_range(2) - 1);
    end else if (roll < 80) begin
      r.req_type = REQ_MULTI;
      if ($urandom_range(4) != 0) begin
        r.pulse_m0 = 8'($urandom_range(40) - 20);
        r.pulse_m1 = 8'($urandom_range(40) - 20);
        r.pulse_m2 = 8'($urandom_range(40) - 20);
        r.pulse_m3 = 8'($urandom_range(40) - 20);
      end
    end else if (roll < 92) begin
      r.req_type = REQ_LOAD;
      if ($urandom_range(9) != 0) begin
        r.load_pos_m0 = 16'($urandom_range(400) - 200);
        r.load_pos_m1 = 16'($urandom_range(400) - 200);
        r.load_pos_m2 = 16'($urandom_range(400) - 200);
        r.load_pos_m3 = 16'($urandom_range(400) - 200);
      end
    end else if (roll < 95) begin
      r.req_type = REQ_SINGLE;  // raw step values, mostly out of range
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  task automatic check_result(rsp_t got);
    rsp_t want;
    status_seen[got.status_code]++;
    if (gate_expected.size() == 0) begin
      report_mismatch("result with nothing outstanding", got.status_code, -1);
      return;
    end
    want = gate_expected.pop_front();
    if (got.status_code !== want.status_code)
      report_mismatch("status_code", got.status_code, want.status_code);
    if (got.step_mask !== want.step_mask)
      report_mismatch("step_mask", got.step_mask, want.step_mask);
    if (got.direction_bits !== want.direction_bits)
      report_mismatch("direction_bits", got.direction_bits, want.direction_bits);
    if (got.delay_us !== want.delay_us)
      report_mismatch("delay_us", got.delay_us, want.delay_us);
    if (got.position_m0 !== want.position_m0)
      report_mismatch("position_m0", got.position_m0, want.position_m0);
    if (got.position_m1 !== want.position_m1)
      report_mismatch("position_m1", got.position_m1, want.position_m1);
    if (got.position_m2 !== want.position_m2)
      report_mismatch("position_m2", got.position_m2, want.position_m2);
    if (got.position_m3 !== want.position_m3)
      report_mismatch("position_m3", got.position_m3, want.position_m3);
  endtask

  task automatic send_item(req_t r, logic known, rsp_t want);
    int   gap;
    rsp_t predicted;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = gate_step(r);
    gate_expected.push_back(known ? want : predicted);
    items_sent++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (gate_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TRAVEL_MIN:  gate_cfg.travel_min  = val;
      CFG_TRAVEL_MAX:  gate_cfg.travel_max  = val;
      CFG_PULSE_DELAY: gate_cfg.pulse_delay = val;
      CFG_ENABLE:      gate_cfg.enable      = val[NumMotors-1:0];
      CFG_INVERT:      gate_cfg.invert      = val[0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic program_phase(int ph);
    logic [CfgW-1:0] lo_lanes;
    logic [CfgW-1:0] hi_lanes;
    logic [CfgW-1:0] dly_lanes;
    for (int i = 0; i < NumMotors; i++) begin
      lo_lanes[16*i +: 16] = 16'(0 - $urandom_range(300));
      hi_lanes[16*i +: 16] = 16'($urandom_range(300));
    end
    dly_lanes = {$urandom, $urandom};
    case (ph)
      2: begin
        lo_lanes  = {4{16'h8000}};
        hi_lanes  = {4{16'h7fff}};
        dly_lanes = {4{16'hffff}};
      end
      3: begin
        hi_lanes  = lo_lanes;  // no room to move at all
        dly_lanes = '0;
      end
      4: begin
        lo_lanes = {4{16'h7fff}};
        hi_lanes = {4{16'h8000}};
      end
      default: ;
    endcase
    write_reg(CFG_TRAVEL_MIN, lo_lanes);
    write_reg(CFG_TRAVEL_MAX, hi_lanes);
    write_reg(CFG_PULSE_DELAY, dly_lanes);
    write_reg(CFG_ENABLE, (ph == 1) ? 64'($urandom_range(15)) : 64'hf);
    write_reg(CFG_INVERT, (ph == 1 || ph == 3) ? 64'd1 :
                          (ph == 5) ? 64'($urandom_range(1)) : 64'd0);
    if (ph == 4) write_reg(CFG_NONE, {$urandom, $urandom});
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_len > 0) begin
      hold_len--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) check_result(rsp_if.data);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (!req_if.valid && gate_expected.size() == 0)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    gate_cfg            = '0;
    gate_cfg.travel_max = TravelMaxReset;
    motor_dir           = '0;
    for (int i = 0; i < NumMotors; i++) motor_pos[i] = '0;
    foreach (status_seen[s]) status_seen[s] = 0;

    // directed: reset state, every error code, partial moves, switch sense
    add_req(mk_req(REQ_SINGLE, 0, 0, 0, 0, 4'h0), 1'b1, mk_rsp(ST_OK, 4'h0));
    add_req(mk_req(REQ_SINGLE, 1, 0, 0, 0, 4'h0), 1'b1, mk_rsp(ST_DISABLED, 4'h0));
    add_req(mk_req(REQ_SINGLE, -1, 0, 0, 0, 4'h0), 1'b1, mk_rsp(ST_DISABLED, 4'h0));
    add_req(mk_req(REQ_SINGLE, 0, 2, 0, 0, 4'h0), 1'b1, mk_rsp(ST_RANGE, 4'h0));
    add_req(mk_req(REQ_SINGLE, -128, 0, 0, 0, 4'h0), 1'b1, mk_rsp(ST_RANGE, 4'h0));
    add_req(mk_req(REQ_MULTI, 0, 0, 0, 0, 4'h0), 1'b1, mk_rsp(ST_OK, 4'h0));
    add_req(mk_req(REQ_MULTI, 127, 0, 0, 0, 4'h0), 1'b1, mk_rsp(ST_DISABLED, 4'h0));
    add_req(mk_req(REQ_SPARE, -1, -1, -1, -1, 4'hf, -1, -1, -1, -1), 1'b1,
            mk_rsp(ST_RANGE, 4'h0));
    add_req(mk_req(REQ_LOAD, 0, 0, 0, 0, 4'h0, 32767, -32768, 0, -1), 1'b1,
            mk_rsp(ST_OK, 4'h0, 32767, -32768, 0, -1));
    add_cfg(CFG_ENABLE, 64'hf);
    add_cfg(CFG_TRAVEL_MIN, {4{16'hff9c}});
    add_cfg(CFG_TRAVEL_MAX, {4{16'h0064}});
    add_cfg(CFG_PULSE_DELAY, 64'h0001_0000_ffff_8000);
    add_req(mk_req(REQ_SINGLE, 1, 0, 0, 0, 4'h0), 1'b1,
            mk_rsp(ST_TRAVEL_MAX, 4'h0, 32767, -32768, 0, -1));
    add_req(mk_req(REQ_SINGLE, 0, -1, 0, 0, 4'h0), 1'b1,
            mk_rsp(ST_TRAVEL_MIN, 4'h0, 32767, -32768, 0, -1));
    add_req(mk_req(REQ_LOAD, 0, 0, 0, 0, 4'h0));
    add_req(mk_req(REQ_SINGLE, 1, 1, 1, 1, 4'h0));
    add_req(mk_req(REQ_SINGLE, -1, -1, -1, -1, 4'b0100));
    add_req(mk_req(REQ_MULTI, 99, -101, 100, 0, 4'h0));
    add_req(mk_req(REQ_MULTI, 1, 0, 0, 0, 4'h0));
    add_req(mk_req(REQ_MULTI, -1, 0, 0, 0, 4'b0001));
    add_cfg(CFG_INVERT, 64'd1);
    add_req(mk_req(REQ_SINGLE, -1, 0, 0, 0, 4'hf));
    add_req(mk_req(REQ_SINGLE, -1, 0, 0, 0, 4'h0));
    add_cfg(CFG_ENABLE, 64'ha);
    add_req(mk_req(REQ_SINGLE, 0, 1, 0, -1, 4'hf));
    add_req(mk_req(REQ_SINGLE, 1, 0, 0, 0, 4'hf));
    add_req(mk_req(REQ_MULTI, 0, 0, 0, -128, 4'hf));
    add_req(mk_req(REQ_SINGLE, 0, 0, 0, 127, 4'hf));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (gate_script[k]) begin
      if (gate_script[k].is_cfg) write_reg(gate_script[k].reg_idx, gate_script[k].reg_val);
      else send_item(gate_script[k].req, gate_script[k].known, gate_script[k].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1:       begin send_idle_pct = 57; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 57; end
        3, 5:    begin send_idle_pct = 25; stall_pct = 25; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      program_phase(ph);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long output stall while items keep coming, then a full pause
        if (ph == 0 && n == 50) hold_len = HOLD_CYCLES;
        if (ph == 0 && n == 100) wait_drained();
        send_item(rand_item(), 1'b0, '0);
      end
    end

    wait_drained();
    $display("Covered %0d items (%0d scripted rows, six random phases) and %0d register writes",
             items_sent, gate_script.size(), reg_writes);
    $display("By status: ok %0d, disabled %0d, travel max %0d, limit min %0d, %s %0d, range %0d",
             status_seen[ST_OK], status_seen[ST_DISABLED], status_seen[ST_TRAVEL_MAX],
             status_seen[ST_LIMIT_MIN], "travel min", status_seen[ST_TRAVEL_MIN],
             status_seen[ST_RANGE]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/qsg_pkg.sv
hdl/qsg_stream_if.sv
hdl/qsg_cfg_regs.sv
hdl/qsg_motor_check.sv
hdl/quad_stepper_step_gate_unit.sv
tb/tb_quad_stepper_step_gate_unit.sv
